// ===== hw/rtl/grs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// grs_pkg: shared types and constants for the group reverse stream unit
// Field widths, configuration reset value and controller states.
// ============================================================================
package grs_pkg;

    localparam int unsigned VAL_W = 16;  // value / value_res field width
    localparam int unsigned GS_W  = 6;   // group_size register width

    localparam logic [GS_W-1:0] GS_RESET = 6'd2;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } t_state;

endpackage : grs_pkg
`default_nettype wire

// ===== hw/rtl/group_reverse_stream_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// group_reverse_stream_unit: reverses a list stream in groups of group_size
// Buffers values in a group memory and drains them reversed (full group) or
// in arrival order (short remainder at the end of a list).
// ============================================================================
// Usage:
//   Input channel (i_valid / o_ready): one list element per beat, i_last on
//   the final element. Output channel (o_valid / i_ready): one reordered
//   element per beat; o_last_of_run marks the final result caused by one
//   input beat, o_end_of_list the final element of the list. Config channel
//   (i_cfg_valid / o_cfg_ready) writes group_size; 0 acts as 1 and values
//   above MAX_GROUP act as MAX_GROUP.
// Timing:
//   A beat that neither closes a group nor ends a list is only stored. A
//   beat that closes a group or ends the list drops o_ready while the group
//   memory is read once per cycle (single read port) while the output queue
//   has room; each read is registered, then queued, and results follow one
//   per cycle while i_ready is high.
// Reset: fill count clears and group_size returns to 2; memory contents are
//   not cleared (only entries of the current group are ever read).
// Stall: a 2-entry output queue with read credit accounting pauses memory
//   reads when no queue entry is left; nothing is dropped. The next input beat is
//   taken once all reads of the group are issued, even with results queued.
// ============================================================================
module group_reverse_stream_unit #(
    parameter int unsigned MAX_GROUP  = 32,
    parameter int unsigned DATA_WIDTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // config
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [grs_pkg::GS_W-1:0]      i_cfg_group_size,
    // input stream
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [grs_pkg::VAL_W-1:0]     i_value,
    input  wire logic                          i_last,
    // output stream
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [grs_pkg::VAL_W-1:0]          o_value_res,
    output logic                               o_last_of_run,
    output logic                               o_end_of_list
);

    // stored width: data masked to DATA_WIDTH and to the 16-bit field
    localparam int unsigned MW = (DATA_WIDTH < grs_pkg::VAL_W) ? DATA_WIDTH
                                                               : grs_pkg::VAL_W;
    localparam int unsigned AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int unsigned CW = $clog2(MAX_GROUP + 1);
    localparam logic [6:0]  MAXG7 = 7'(MAX_GROUP);

    // ------------------------------------------------------------------
    // Config register
    // ------------------------------------------------------------------
    logic [grs_pkg::GS_W-1:0] r_group_size;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= grs_pkg::GS_RESET;
        end else if (i_cfg_valid) begin
            r_group_size <= i_cfg_group_size;
        end
    end

    // effective group size: zero reads as one, saturate at MAX_GROUP
    logic [6:0] gs7;
    logic [6:0] k7;
    assign gs7 = {1'b0, r_group_size};
    assign k7  = (gs7 == 7'd0) ? 7'd1 : ((gs7 > MAXG7) ? MAXG7 : gs7);

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    grs_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_fill,  n_fill;
    logic [AW-1:0]   r_idx,   n_idx;
    logic [AW-1:0]   r_lim,   n_lim;
    logic            r_rev,   n_rev;
    logic            r_lst,   n_lst;

    logic            in_acc;
    logic [CW-1:0]   fill_inc;
    logic [CW-1:0]   fill_dec;
    logic            rd_en;
    logic            rd_fin;
    logic            can_issue;
    logic            pop;

    // output queue / read tracking
    logic [1:0]      r_cnt;
    logic            r_pend;
    logic            r_pend_run;
    logic            r_pend_eol;

    assign in_acc   = i_valid && o_ready;
    assign fill_inc = r_fill + CW'(1);
    assign fill_dec = fill_inc - CW'(1);
    assign pop      = o_valid && i_ready;
    // room for one more read after this cycle's pop
    assign can_issue = ({1'b0, r_cnt} + {2'b00, r_pend}) <= (3'd1 + {2'b00, pop});
    assign rd_fin    = r_rev ? (r_idx == '0) : (r_idx == r_lim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= grs_pkg::ST_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_lim <= n_lim;
        r_rev <= n_rev;
        r_lst <= n_lst;
    end

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_idx   = r_idx;
        n_lim   = r_lim;
        n_rev   = r_rev;
        n_lst   = r_lst;
        o_ready = 1'b0;
        rd_en   = 1'b0;
        unique case (r_state)
            grs_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (7'(fill_inc) >= k7) begin
                        // full group (or more after a size change): reversed
                        n_state = grs_pkg::ST_DRAIN;
                        n_rev   = 1'b1;
                        n_idx   = AW'(fill_dec);
                        n_lst   = i_last;
                        n_fill  = '0;
                    end else if (i_last) begin
                        // short remainder: arrival order
                        n_state = grs_pkg::ST_DRAIN;
                        n_rev   = 1'b0;
                        n_idx   = '0;
                        n_lim   = AW'(fill_dec);
                        n_lst   = 1'b1;
                        n_fill  = '0;
                    end else begin
                        n_fill  = fill_inc;
                    end
                end
            end
            grs_pkg::ST_DRAIN: begin
                if (can_issue) begin
                    rd_en = 1'b1;
                    if (rd_fin) begin
                        n_state = grs_pkg::ST_IDLE;
                    end else if (r_rev) begin
                        n_idx = r_idx - AW'(1);
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end
            end
            default: begin
                n_state = grs_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Group memory: one write port, one registered read port
    // ------------------------------------------------------------------
    logic [MW-1:0] r_mem [MAX_GROUP];
    logic [MW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mem[AW'(r_fill)] <= MW'(i_value);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_pend_run <= rd_fin;
            r_pend_eol <= rd_fin && r_lst;
        end
    end

    // ------------------------------------------------------------------
    // Output queue, 2 entries
    // ------------------------------------------------------------------
    logic [MW-1:0] r_q_val [2];
    logic          r_q_run [2];
    logic          r_q_eol [2];
    logic          r_wp;
    logic          r_rp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + {1'b0, r_pend} - {1'b0, pop};
            if (r_pend) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_q_val[r_wp] <= r_rd_data;
            r_q_run[r_wp] <= r_pend_run;
            r_q_eol[r_wp] <= r_pend_eol;
        end
    end

    assign o_valid       = (r_cnt != 2'd0);
    assign o_value_res   = grs_pkg::VAL_W'(r_q_val[r_rp]);
    assign o_last_of_run = r_q_run[r_rp];
    assign o_end_of_list = r_q_eol[r_rp];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_cnt} + {2'b00, r_pend}) <= 3'd2)
        else $error("output queue overrun");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_last) |=> (r_fill == '0))
        else $error("fill count not cleared at end of list");

    a_eol_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_end_of_list) |-> o_last_of_run)
        else $error("end of list without end of run");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) < MAX_GROUP)
        else $error("fill count out of range");

endmodule : group_reverse_stream_unit
`default_nettype wire

// ===== tb/sv/group_reverse_stream_unit_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// group_reverse_stream_unit_tb: self-checking bench for the group reverser
// Drives list beats and group_size writes with random gaps, predicts each
// reordered beat in a behavioral model or a typed-in row, checks it in order.
// ============================================================================
module group_reverse_stream_unit_tb;

    localparam int MAX_GROUP   = 32;
    localparam int MAX_GAP     = 11;   // longest per-beat idle on either side
    localparam int SETTLE_CYC  = 8;    // block may still be absorbing a beat
    localparam int DRAIN_CYC   = 40;   // quiet time after the last result
    localparam int HOLD_AT     = 120;  // results seen before the long hold
    localparam int HOLD_CYC    = 300;  // receiver hold length
    localparam int NUM_PHASES  = 11;
    localparam int PHASE_BEATS = 46;
    localparam int N_DIR       = 21;
    localparam int MAX_REPORTS = 10;

    // one output beat
    typedef struct packed {
        logic [grs_pkg::VAL_W-1:0] val;
        logic                      run_end;
        logic                      list_end;
    } t_res;

    // directed table row: either a group_size write or one list beat,
    // optionally with its single result typed in
    typedef struct packed {
        bit                        is_cfg;
        logic [grs_pkg::GS_W-1:0]  gs;
        logic [grs_pkg::VAL_W-1:0] val;
        logic                      tail;
        bit                        chk;
        logic [grs_pkg::VAL_W-1:0] x_val;
        logic                      x_run_end;
        logic                      x_list_end;
    } t_row;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [grs_pkg::GS_W-1:0]  i_cfg_group_size;
    logic                      i_valid;
    logic                      o_ready;
    logic [grs_pkg::VAL_W-1:0] i_value;
    logic                      i_last;
    logic                      o_valid;
    logic                      i_ready;
    logic [grs_pkg::VAL_W-1:0] o_value_res;
    logic                      o_last_of_run;
    logic                      o_end_of_list;

    // typed-in expectation travels with the beat so the checker sees it
    // at the same edge the beat is taken
    logic                      chk_row;
    logic [grs_pkg::VAL_W-1:0] x_val;
    logic                      x_run_end;
    logic                      x_list_end;

    // behavioral copy of the block
    logic [grs_pkg::VAL_W-1:0] grp_mem [MAX_GROUP];
    int                        fill_cnt;
    logic [grs_pkg::GS_W-1:0]  gs_reg;
    t_res                      beat_res [$];
    t_res                      pending_out [$];

    int err_cnt     = 0;
    int beats_in    = 0;
    int res_cnt     = 0;
    int cfg_cnt     = 0;
    int stall_cyc   = 0;
    int src_gap_max = MAX_GAP;
    int snk_gap_max = MAX_GAP;
    bit hold_done   = 1'b0;
    bit hold_active = 1'b0;

    t_row dir_tbl [N_DIR] = '{
        // reset size 2: a lone beat is a short list, passes through as is
        '{1'b0, 6'd0,  16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b1},
        '{1'b0, 6'd0,  16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{1'b0, 6'd0,  16'h1234, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{1'b0, 6'd0,  16'hAAAA, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        // end of list lands exactly on a full group
        '{1'b0, 6'd0,  16'h5555, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
        // size zero acts as one: straight pass
        '{1'b1, 6'd0,  16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{1'b0, 6'd0,  16'hFFFF, 1'b0, 1'b1, 16'hFFFF, 1'b1, 1'b0},
        '{1'b0, 6'd0,  16'h0001, 1'b1, 1'b1, 16'h0001, 1'b1, 1'b1},
        // oversize saturates; short list comes out in arrival order
        '{1'b1, 6'd33, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{1'b0, 6'd0,  16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{1'b0, 6'd0,  16'h7FFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{1'b0, 6'd0,  16'h0F0F, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
        // shrink the group while three values sit in the buffer
        '{1'b1, 6'd4,  16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{1'b0, 6'd0,  16'h0001, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{1'b0, 6'd0,  16'h0002, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{1'b0, 6'd0,  16'h0003, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{1'b1, 6'd2,  16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{1'b0, 6'd0,  16'h00FF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{1'b0, 6'd0,  16'hC3C3, 1'b1, 1'b1, 16'hC3C3, 1'b1, 1'b1},
        '{1'b1, 6'd1,  16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{1'b0, 6'd0,  16'h2468, 1'b1, 1'b1, 16'h2468, 1'b1, 1'b1}
    };

    group_reverse_stream_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_group_size (i_cfg_group_size),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_value          (i_value),
        .i_last           (i_last),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_value_res      (o_value_res),
        .o_last_of_run    (o_last_of_run),
        .o_end_of_list    (o_end_of_list)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Reorder prediction for one accepted beat. Stores the value, then either
    // flushes a full group newest-first, flushes a short tail oldest-first
    // when the list ends, or emits nothing.
    // ------------------------------------------------------------------------
    function automatic void reorder_beat(input logic [grs_pkg::VAL_W-1:0] v,
                                         input logic tail);
        int k;
        int n;
        k = (gs_reg == 0) ? 1 : ((gs_reg > MAX_GROUP) ? MAX_GROUP : int'(gs_reg));
        beat_res.delete();
        if (fill_cnt >= MAX_GROUP) fill_cnt = 0;
        grp_mem[fill_cnt] = v;
        fill_cnt++;
        n = fill_cnt;
        if (n >= k) begin
            // full group (or more, after a shrink): newest first
            for (int i = n - 1; i >= 0; i--)
                beat_res.push_back(t_res'{grp_mem[i], i == 0, (i == 0) && tail});
            fill_cnt = 0;
        end else if (tail) begin
            // short remainder keeps arrival order
            for (int i = 0; i < n; i++)
                beat_res.push_back(t_res'{grp_mem[i], i == n - 1, i == n - 1});
            fill_cnt = 0;
        end
    endfunction

    function automatic void log_fault(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) $display("[%0t] %s", $realtime, msg);
    endfunction

    // ------------------------------------------------------------------------
    // Checker: all handshakes are observed at the rising edge. The predictor
    // runs before the output compare so that ordering inside a step never
    // matters.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_proc
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            fill_cnt = 0;
            gs_reg   = grs_pkg::GS_RESET;
        end else begin
            if (i_cfg_valid && o_cfg_ready) gs_reg = i_cfg_group_size;
            if (hold_active && i_valid && !o_ready) stall_cyc++;
            if (i_valid && o_ready) begin
                beats_in++;
                reorder_beat(i_value, i_last);
                if (chk_row)
                    pending_out.push_back(t_res'{x_val, x_run_end, x_list_end});
                else
                    foreach (beat_res[j]) pending_out.push_back(beat_res[j]);
            end
            if (o_valid && i_ready) begin
                res_cnt++;
                got = t_res'{o_value_res, o_last_of_run, o_end_of_list};
                if (pending_out.size() == 0) begin
                    log_fault($sformatf("UNEXPECTED beat value=%h run_end=%b list_end=%b",
                                        got.val, got.run_end, got.list_end));
                end else begin
                    want = pending_out.pop_front();
                    if (got.val !== want.val || got.run_end !== want.run_end ||
                        got.list_end !== want.list_end)
                        log_fault($sformatf({"MISMATCH result %0d: value %h/%h ",
                                             "run_end %b/%b list_end %b/%b (exp/act)"},
                                            res_cnt, want.val, got.val,
                                            want.run_end, got.run_end,
                                            want.list_end, got.list_end));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random per-beat gaps, plus one long hold while the sender
    // keeps pushing so the buffer backs up into o_ready.
    // ------------------------------------------------------------------------
    initial begin : sink_proc
        int gap;
        i_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (!hold_done && res_cnt >= HOLD_AT) begin
                hold_done   = 1'b1;
                hold_active = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYC) @(negedge i_clk);
                hold_active = 1'b0;
            end
            gap = $urandom_range(0, snk_gap_max);
            if (gap != 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    // Sender: one list beat. Entered and left at a falling edge; valid is
    // left high so back-to-back beats never drop it.
    task automatic put_beat(input logic [grs_pkg::VAL_W-1:0] v, input logic tail,
                            input logic chk, input logic [grs_pkg::VAL_W-1:0] xv,
                            input logic xr, input logic xl);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_value    <= v;
        i_last     <= tail;
        chk_row    <= chk;
        x_val      <= xv;
        x_run_end  <= xr;
        x_list_end <= xl;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // group_size write, only once every predicted result is out and the
    // block has had time to finish absorbing a beat that produced nothing
    task automatic write_group_size(input logic [grs_pkg::GS_W-1:0] gs);
        i_valid <= 1'b0;
        while (pending_out.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
        i_cfg_valid      <= 1'b1;
        i_cfg_group_size <= gs;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_cnt++;
    endtask

    function automatic logic [grs_pkg::VAL_W-1:0] rand_val();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return grs_pkg::VAL_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed table, then random phases. Each phase
    // sets a group size (extremes first) and an idle profile, then sends
    // lists whose lengths mostly close whole groups, with short tails and
    // lists cut off by the next size change mixed in.
    // ------------------------------------------------------------------------
    initial begin : stim_proc
        int gs_plan [8];
        int gs;
        int k;
        int len;
        int sent;
        gs_plan          = '{63, 32, 1, 0, 3, 33, 7, 2};
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_value          <= '0;
        i_last           <= 1'b0;
        i_cfg_valid      <= 1'b0;
        i_cfg_group_size <= '0;
        chk_row          <= 1'b0;
        x_val            <= '0;
        x_run_end        <= 1'b0;
        x_list_end       <= 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tbl[r]) begin
            if (dir_tbl[r].is_cfg)
                write_group_size(dir_tbl[r].gs);
            else
                put_beat(dir_tbl[r].val, dir_tbl[r].tail, dir_tbl[r].chk,
                         dir_tbl[r].x_val, dir_tbl[r].x_run_end, dir_tbl[r].x_list_end);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            gs = (ph < 8) ? gs_plan[ph] : $urandom_range(2, 12);
            write_group_size(grs_pkg::GS_W'(gs));
            k = (gs == 0) ? 1 : ((gs > MAX_GROUP) ? MAX_GROUP : gs);
            // idle profile: both random, sender flat out, receiver flat out, none
            src_gap_max = (ph % 4 == 1 || ph % 4 == 3) ? 0 : MAX_GAP;
            snk_gap_max = (ph % 4 == 2 || ph % 4 == 3) ? 0 : MAX_GAP;
            sent = 0;
            while (sent < PHASE_BEATS) begin
                case ($urandom_range(0, 7))
                    0, 1, 2, 3, 4: len = k * $urandom_range(1, 3);
                    5, 6:          len = k * $urandom_range(0, 2) +
                                         ((k > 1) ? $urandom_range(1, k - 1) : 1);
                    default:       len = $urandom_range(1, k);
                endcase
                for (int j = 0; j < len && sent < PHASE_BEATS; j++) begin
                    put_beat(rand_val(), j == len - 1, 1'b0, '0, 1'b0, 1'b0);
                    sent++;
                end
            end
        end
        // closing beat flushes whatever partial group is left
        put_beat(rand_val(), 1'b1, 1'b0, '0, 1'b0, 1'b0);
        i_valid <= 1'b0;

        while (pending_out.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYC) @(negedge i_clk);

        $display("Summary: %0d list beats in, %0d reordered beats checked, %0d group_size writes",
                 beats_in, res_cnt, cfg_cnt);
        $display("Summary: sizes 0,1,2,32,33,63 plus mid-group shrink; input stalled %0d cycles%s",
                 stall_cyc, " during receiver hold");
        if (err_cnt == 0) begin
            $display("group_reverse_stream_unit verification clean");
        end else begin
            $display("%0d errors", err_cnt);
            $display("group_reverse_stream_unit verification failed");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin : watchdog_proc
        #20ms;
        $display("TIMEOUT with %0d results outstanding", pending_out.size());
        $display("group_reverse_stream_unit verification failed");
        $finish;
    end

endmodule
